FILE: hw/rtl/mcr_pkg.sv
// Shared types and constants of the midpoint circle rasterizer.
// No dependencies; every other file of the block refers to it by scoped names.
package mcr_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam int COORD_W  = 10;
  localparam int OFFSET_W = 11;
  localparam int DEC_W    = 16;
  localparam int PIXEL_W  = 12;

  // Radius bits that take part; the port is COORD_W bits wide
  localparam int RADIUS_EFF = (RADIUS_BITS < COORD_W) ? RADIUS_BITS : COORD_W;
  localparam logic [COORD_W-1:0] RADIUS_MASK = COORD_W'((1 << RADIUS_EFF) - 1);

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] pixel_x;
    logic signed [PIXEL_W-1:0] pixel_y;
    logic                      pixel_valid;
    logic                      last_of_step;
    logic                      circle_done;
  } out_item_t;

  // One classified step, handed from front to back
  typedef struct packed {
    logic                       has_pixels;
    logic                       circle_done;
    logic [COORD_W-1:0]         cx;
    logic [COORD_W-1:0]         cy;
    logic signed [OFFSET_W-1:0] ox;
    logic signed [OFFSET_W-1:0] oy;
  } step_cmd_t;

  // Handshake between two parts
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

FILE: hw/rtl/mcr_front.sv
// Front part: accepts items, keeps the circle state and classifies each step.
// Depends on mcr_pkg.
module mcr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mcr_pkg::in_item_t   item,
  output mcr_pkg::link_t      cmd_link,
  input  logic                cmd_full,
  output mcr_pkg::step_cmd_t  cmd
);

  logic signed [mcr_pkg::OFFSET_W-1:0] offset_x;
  logic signed [mcr_pkg::OFFSET_W-1:0] offset_y;
  logic signed [mcr_pkg::DEC_W-1:0]    decision;
  logic [mcr_pkg::COORD_W-1:0]         center_col;
  logic [mcr_pkg::COORD_W-1:0]         center_row;
  logic                                circle_active;

  logic                                accept;
  logic                                step_live;
  logic [mcr_pkg::COORD_W-1:0]         radius_m;
  logic signed [mcr_pkg::DEC_W-1:0]    x_w;
  logic signed [mcr_pkg::DEC_W-1:0]    y_w;
  logic signed [mcr_pkg::DEC_W-1:0]    decision_next;
  logic signed [mcr_pkg::OFFSET_W-1:0] offset_x_next;
  logic signed [mcr_pkg::OFFSET_W-1:0] offset_y_next;
  logic                                done_next;

  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign step_live = circle_active && !(offset_x > offset_y);
  assign radius_m  = item.radius & mcr_pkg::RADIUS_MASK;

  assign x_w = mcr_pkg::DEC_W'(offset_x);
  assign y_w = mcr_pkg::DEC_W'(offset_y);

  always_comb begin
    offset_x_next = offset_x + mcr_pkg::OFFSET_W'(1);
    if (decision[mcr_pkg::DEC_W-1]) begin
      decision_next = decision + (x_w <<< 2) + mcr_pkg::DEC_W'(6);
      offset_y_next = offset_y;
    end else begin
      decision_next = decision + ((x_w - y_w) <<< 2) + mcr_pkg::DEC_W'(10);
      offset_y_next = offset_y - mcr_pkg::OFFSET_W'(1);
    end
    done_next = offset_x_next > offset_y_next;
  end

  assign cmd_link.valid = accept && (item.mode == mcr_pkg::MODE_STEP);
  assign cmd_link.ready = !cmd_full;

  always_comb begin
    cmd.has_pixels  = step_live;
    cmd.circle_done = step_live ? done_next : 1'b1;
    cmd.cx          = center_col;
    cmd.cy          = center_row;
    cmd.ox          = offset_x;
    cmd.oy          = offset_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_active <= 1'b0;
      offset_x      <= '0;
      offset_y      <= '0;
      decision      <= '0;
      center_col    <= '0;
      center_row    <= '0;
    end else if (accept) begin
      if (item.mode == mcr_pkg::MODE_LOAD) begin
        center_col    <= item.center_x;
        center_row    <= item.center_y;
        offset_x      <= '0;
        offset_y      <= mcr_pkg::OFFSET_W'(radius_m);
        decision      <= mcr_pkg::DEC_W'(3) - {{(mcr_pkg::DEC_W-mcr_pkg::COORD_W-1){1'b0}},
                                               radius_m, 1'b0};
        circle_active <= 1'b1;
      end else if (step_live) begin
        offset_x      <= offset_x_next;
        offset_y      <= offset_y_next;
        decision      <= decision_next;
        circle_active <= !done_next;
      end else begin
        circle_active <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/mcr_queue.sv
// Short command queue between front and back parts.
// Depends on mcr_pkg for the command type.
module mcr_queue #(
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  mcr_pkg::link_t     wr_link,
  input  mcr_pkg::step_cmd_t wr_data,
  output logic               q_full,
  input  logic               rd_pop,
  output logic               q_empty,
  output mcr_pkg::step_cmd_t rd_data
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcr_pkg::step_cmd_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = count == CNT_W'(DEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr_link.valid && wr_link.ready;
  assign do_rd   = rd_pop && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/mcr_back.sv
// Back part: expands each step into its eight symmetric pixels, one a cycle
// unless stalled; a pixel-less step gives one invalid result. Uses mcr_pkg.
module mcr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  mcr_pkg::step_cmd_t head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output mcr_pkg::out_item_t result
);

  logic [2:0]                         octant;
  logic                               out_valid;
  logic                               load;
  logic                               last;
  logic signed [mcr_pkg::PIXEL_W-1:0] u;
  logic signed [mcr_pkg::PIXEL_W-1:0] v;
  logic signed [mcr_pkg::PIXEL_W-1:0] cx_w;
  logic signed [mcr_pkg::PIXEL_W-1:0] cy_w;
  mcr_pkg::out_item_t                 next_item;

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign last  = !head.has_pixels || (octant == 3'd7);
  assign q_pop = load && last;

  always_comb begin
    cx_w = mcr_pkg::PIXEL_W'(head.cx);
    cy_w = mcr_pkg::PIXEL_W'(head.cy);
    // upper four swap the roles of the two offsets
    u = octant[2] ? mcr_pkg::PIXEL_W'(head.oy) : mcr_pkg::PIXEL_W'(head.ox);
    v = octant[2] ? mcr_pkg::PIXEL_W'(head.ox) : mcr_pkg::PIXEL_W'(head.oy);
    next_item.pixel_x      = (octant[0] ^ octant[1]) ? cx_w - u : cx_w + u;
    next_item.pixel_y      = octant[1] ? cy_w - v : cy_w + v;
    next_item.pixel_valid  = 1'b1;
    next_item.last_of_step = last;
    next_item.circle_done  = head.circle_done;
    if (!head.has_pixels) begin
      next_item.pixel_x     = '0;
      next_item.pixel_y     = '0;
      next_item.pixel_valid = 1'b0;
      next_item.circle_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      octant    <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      octant    <= last ? 3'd0 : octant + 3'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer: front, command queue and back part.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
// Load items (mode 0) latch a centre and radius and produce no result; step items
// (mode 1) produce the eight octant pixels of the current offset, or one result
// with pixel_valid low and circle_done high when no circle is active. The front
// takes one item per cycle while its command queue (QUEUE_DEPTH entries) has room;
// loads never reach the queue. The back part drains the queue and presents one
// result per cycle while the consumer pops, so a step costs eight results and an
// inactive step one. Sustained throughput is therefore set by the single-pixel
// output register; short bursts of up to QUEUE_DEPTH steps are absorbed by the
// queue. A result is loaded into the output register once its command reaches
// the queue head and that register is free or being popped.
module midpoint_circle_rasterizer_top #(
  parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mcr_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output mcr_pkg::out_item_t result
);

  mcr_pkg::link_t     cmd_link;
  mcr_pkg::step_cmd_t cmd;
  mcr_pkg::step_cmd_t head;
  logic               cmd_full;
  logic               q_empty;
  logic               q_pop;

  // classify requests and advance the octant walk
  mcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_link (cmd_link),
    .cmd_full (cmd_full),
    .cmd      (cmd)
  );

  // hold pending steps so front and back stall independently
  mcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_link (cmd_link),
    .wr_data (cmd),
    .q_full  (cmd_full),
    .rd_pop  (q_pop),
    .q_empty (q_empty),
    .rd_data (head)
  );

  // expand each step into pixels and register them for the consumer
  mcr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

FILE: hw/rtl/mcr_checker.sv
// Port-level checks on the midpoint circle rasterizer, bound to its top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer_top.
module mcr_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input mcr_pkg::out_item_t result
);

  // drop every waiting result on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results pending after reset");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  a_invalid_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.pixel_valid) |-> (result.last_of_step && result.circle_done))
    else $error("invalid result not final");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.pixel_valid) |-> (result.pixel_x == '0 && result.pixel_y == '0))
    else $error("invalid result carries coordinates");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_checker (.*);
